// ===== design/bblur_pkg.sv =====
`timescale 1ns / 1ps

package bblur_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);

  // Division by 2*count is a multiply by a rounded-up reciprocal. With a
  // numerator below 2**13 and a divisor up to 18, 19 fraction bits are exact.
  localparam int QUO_SHIFT = 19;
  localparam logic [18:0] RECIP [16] = '{
    19'd0,      19'd262144, 19'd131072, 19'd87382,
    19'd65536,  19'd52429,  19'd43691,  19'd37450,
    19'd32768,  19'd29128,  19'd0,      19'd0,
    19'd0,      19'd0,      19'd0,      19'd0
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_P_READ,
    S_P_LOAD,
    S_E_SUM,
    S_E_DIV,
    S_E_OUT,
    S_D_READ,
    S_D_LOAD
  } state_t;

  typedef enum logic [1:0] {
    K_FIRST,
    K_SECOND,
    K_DRAIN
  } kind_t;

  typedef struct packed {
    logic              cap;
    logic              mem_rd;
    logic              mem_wr;
    logic [ADDR_W-1:0] addr;
    logic              wr_bank;
    logic              win_shift;
    logic              top_bank;
    logic              sum_en;
    logic              sh;
    logic [2:0]        cv;
    logic [2:0]        rv;
    logic              fe;
    logic              div_en;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ===== design/box_blur_3x3_edge_aware_top.sv =====
`timescale 1ns / 1ps
// Channel   Handshake              Fields
// input     in_valid / in_ready    command, red_in, green_in, blue_in
// output    out_valid / out_ready  red_out, green_out, blue_out, frame_end
// config    cfg_we                 cfg_index, cfg_data
//
// A pixel is accepted, read from the line banks and loaded into the window; each
// word it yields adds a sum, a reciprocal multiply and an output load step.
// A drain tick makes three column reads of the two line banks, each addressed
// and then loaded, followed by the same sum, multiply and output load steps.
// Reset is synchronous; line banks and window hold no reset value.
// A word waiting at the output stalls only the emit step that needs the slot.

module box_blur_3x3_edge_aware_top import bblur_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        frame_end,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  bblur_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (command),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  bblur_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .out_ready (out_ready),
    .stat      (stat),
    .out_valid (out_valid),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .frame_end (frame_end)
  );

  a_single_port: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_wr |-> !cmd.mem_rd)
    else $error("line bank read and write in the same cycle");

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("output word overwritten before it was taken");

  a_fresh_read: assert property (@(posedge clk) disable iff (rst)
    cmd.win_shift |-> $past(cmd.mem_rd))
    else $error("window loaded without a fresh line bank read");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_rd |-> !in_ready)
    else $error("second word accepted while one is in work");

endmodule

// ===== design/bblur_ctrl.sv =====
`timescale 1ns / 1ps

module bblur_ctrl import bblur_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        command,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  stat_t       stat,
  output logic        in_ready,
  output cmd_t        cmd
);

  state_t      state, state_next;
  kind_t       kind, kind_next;
  logic [1:0]  dk, dk_next;
  logic        draining;
  logic [9:0]  in_column;
  logic [11:0] in_row;
  logic [10:0] drain_column;
  logic [10:0] frame_width;
  logic [12:0] frame_height;

  logic [10:0] w, col, dcol, daddr;
  logic [12:0] h;
  logic        row_end, frame_done, d_last, has_first, has_second;
  logic        px_done, dr_done;

  always_comb begin
    if (frame_width == 11'd0) w = 11'd1;
    else if (frame_width > 11'(MAX_WIDTH)) w = 11'(MAX_WIDTH);
    else w = frame_width;
    if (frame_height == 13'd0) h = 13'd1;
    else if (frame_height > 13'(MAX_HEIGHT)) h = 13'(MAX_HEIGHT);
    else h = frame_height;
    col  = ({1'b0, in_column} >= w) ? w - 11'd1 : {1'b0, in_column};
    dcol = (drain_column >= w) ? w - 11'd1 : drain_column;
  end

  assign row_end    = (col + 11'd1) >= w;
  assign frame_done = ({1'b0, in_row} + 13'd1) >= h;
  assign d_last     = (dcol + 11'd1) >= w;
  assign has_first  = (in_row != 12'd0) && (col != 11'd0);
  assign has_second = (in_row != 12'd0) && row_end;

  // The drain window is read one column at a time, left, center, right.
  always_comb begin
    case (dk)
      2'd0:    daddr = (dcol != 11'd0) ? dcol - 11'd1 : dcol;
      2'd1:    daddr = dcol;
      default: daddr = d_last ? dcol : dcol + 11'd1;
    endcase
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    dk_next    = dk;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!command && !draining) begin
            state_next = S_P_READ;
          end else if (command && draining) begin
            state_next = S_D_READ;
            dk_next    = 2'd0;
          end
        end
      end
      S_P_READ: state_next = S_P_LOAD;
      S_P_LOAD: begin
        if (has_first) begin
          state_next = S_E_SUM;
          kind_next  = K_FIRST;
        end else if (has_second) begin
          state_next = S_E_SUM;
          kind_next  = K_SECOND;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_E_SUM: state_next = S_E_DIV;
      S_E_DIV: state_next = S_E_OUT;
      S_E_OUT: begin
        if (stat.out_free) begin
          if (kind == K_FIRST && has_second) begin
            state_next = S_E_SUM;
            kind_next  = K_SECOND;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_D_READ: state_next = S_D_LOAD;
      S_D_LOAD: begin
        if (dk == 2'd2) begin
          state_next = S_E_SUM;
          kind_next  = K_DRAIN;
        end else begin
          state_next = S_D_READ;
          dk_next    = dk + 2'd1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    px_done  = 1'b0;
    dr_done  = 1'b0;
    in_ready = (state == S_IDLE);
    cmd.cap  = (state == S_IDLE) && in_valid;
    unique case (state)
      S_P_READ: begin
        cmd.mem_rd = 1'b1;
        cmd.addr   = col[ADDR_W-1:0];
      end
      S_P_LOAD: begin
        cmd.win_shift = 1'b1;
        cmd.top_bank  = in_row[0];
        cmd.mem_wr    = 1'b1;
        cmd.wr_bank   = in_row[0];
        cmd.addr      = col[ADDR_W-1:0];
        px_done       = !has_first && !has_second;
      end
      S_E_SUM: begin
        cmd.sum_en = 1'b1;
        unique case (kind)
          K_FIRST: begin
            cmd.sh = 1'b0;
            cmd.cv = {1'b1, 1'b1, col >= 11'd2};
            cmd.rv = {1'b1, 1'b1, in_row >= 12'd2};
          end
          K_SECOND: begin
            cmd.sh = 1'b1;
            cmd.cv = {1'b0, 1'b1, col != 11'd0};
            cmd.rv = {1'b1, 1'b1, in_row >= 12'd2};
          end
          default: begin
            cmd.sh = 1'b0;
            cmd.cv = {!d_last, 1'b1, dcol != 11'd0};
            cmd.rv = {1'b0, 1'b1, in_row != 12'd0};
            cmd.fe = d_last;
          end
        endcase
      end
      S_E_DIV: cmd.div_en = 1'b1;
      S_E_OUT: begin
        cmd.out_load = stat.out_free;
        dr_done      = stat.out_free && (kind == K_DRAIN);
        px_done      = stat.out_free && (kind != K_DRAIN) &&
                       !(kind == K_FIRST && has_second);
      end
      S_D_READ: begin
        cmd.mem_rd = 1'b1;
        cmd.addr   = daddr[ADDR_W-1:0];
      end
      S_D_LOAD: begin
        cmd.win_shift = 1'b1;
        cmd.top_bank  = ~in_row[0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      kind         <= K_FIRST;
      dk           <= 2'd0;
      draining     <= 1'b0;
      in_column    <= '0;
      in_row       <= '0;
      drain_column <= '0;
      frame_width  <= 11'd1024;
      frame_height <= 13'd768;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      dk    <= dk_next;
      if (cfg_we) begin
        if (cfg_index) frame_height <= cfg_data;
        else frame_width <= cfg_data[10:0];
      end
      if (px_done) begin
        if (row_end) begin
          in_column <= '0;
          if (frame_done) begin
            draining     <= 1'b1;
            drain_column <= '0;
          end else begin
            in_row <= in_row + 12'd1;
          end
        end else begin
          in_column <= col[9:0] + 10'd1;
        end
      end
      if (dr_done) begin
        if (cmd.fe || d_last) begin
          in_column    <= '0;
          in_row       <= '0;
          drain_column <= '0;
          draining     <= 1'b0;
        end else begin
          drain_column <= dcol + 11'd1;
        end
      end
    end
  end

endmodule

// ===== design/bblur_dp.sv =====
`timescale 1ns / 1ps

module bblur_dp import bblur_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic       out_ready,
  output stat_t      stat,
  output logic       out_valid,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic       frame_end
);

  logic [23:0] mem0 [MAX_WIDTH];
  logic [23:0] mem1 [MAX_WIDTH];
  logic [23:0] rd0, rd1, px;
  logic [23:0] win [3][3];

  logic [23:0] pick;
  logic        en;
  logic [11:0] s_r, s_g, s_b, sum_r, sum_g, sum_b;
  logic [3:0]  cnt, cnt_q;
  logic        fe_q, fe_q2;
  logic [12:0] num_r, num_g, num_b;
  logic [31:0] prod_r, prod_g, prod_b;

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd0 <= mem0[cmd.addr];
      rd1 <= mem1[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && !cmd.wr_bank) mem0[cmd.addr] <= px;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && cmd.wr_bank) mem1[cmd.addr] <= px;
  end

  // The top row comes from the bank selected by top_bank, the middle row from
  // the other one, and the bottom row is the pixel just taken.
  always_ff @(posedge clk) begin
    if (cmd.cap) px <= {red_in, green_in, blue_in};
    if (cmd.win_shift) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= cmd.top_bank ? rd1 : rd0;
      win[1][2] <= cmd.top_bank ? rd0 : rd1;
      win[2][2] <= px;
    end
  end

  always_comb begin
    s_r = '0;
    s_g = '0;
    s_b = '0;
    cnt = '0;
    pick = '0;
    en = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        en   = cmd.rv[i] && cmd.cv[j];
        pick = cmd.sh ? win[i][(j == 2) ? 2 : j + 1] : win[i][j];
        if (en) begin
          s_r = s_r + {4'd0, pick[23:16]};
          s_g = s_g + {4'd0, pick[15:8]};
          s_b = s_b + {4'd0, pick[7:0]};
          cnt = cnt + 4'd1;
        end
      end
    end
  end

  assign num_r = {sum_r, 1'b0} + {9'd0, cnt_q};
  assign num_g = {sum_g, 1'b0} + {9'd0, cnt_q};
  assign num_b = {sum_b, 1'b0} + {9'd0, cnt_q};

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      sum_r <= s_r;
      sum_g <= s_g;
      sum_b <= s_b;
      cnt_q <= cnt;
      fe_q  <= cmd.fe;
    end
    if (cmd.div_en) begin
      prod_r <= num_r * RECIP[cnt_q];
      prod_g <= num_g * RECIP[cnt_q];
      prod_b <= num_b * RECIP[cnt_q];
      fe_q2  <= fe_q;
    end
    if (cmd.out_load) begin
      red_out   <= prod_r[QUO_SHIFT+7:QUO_SHIFT];
      green_out <= prod_g[QUO_SHIFT+7:QUO_SHIFT];
      blue_out  <= prod_b[QUO_SHIFT+7:QUO_SHIFT];
      frame_end <= fe_q2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

// ===== test/box_blur_3x3_edge_aware_top_test.sv =====
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware_top_test;
  import bblur_pkg::*;

  typedef enum logic {CMD_PIXEL = 1'b0, CMD_DRAIN = 1'b1} blur_cmd_t;
  typedef enum logic {REG_WIDTH = 1'b0, REG_HEIGHT = 1'b1} blur_reg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       fe;
  } blur_pix_t;

  class blur_board;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [23:0] lines [2*MAX_WIDTH];
    logic [23:0] win [9];
    int unsigned col, row, dcol;
    bit draining;
    blur_pix_t want [$];
    int errors;

    function void reset_state();
      width_reg = 11'd1024;
      height_reg = 13'd768;
      foreach (lines[i]) lines[i] = '0;
      foreach (win[i]) win[i] = '0;
      col = 0;
      row = 0;
      dcol = 0;
      draining = 0;
      want.delete();
      errors = 0;
    endfunction

    function void write_reg(blur_reg_t idx, logic [12:0] value);
      if (idx == REG_WIDTH) width_reg = value[10:0];
      else height_reg = value;
    endfunction

    function int unsigned eff_w();
      if (width_reg < 1) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg < 1) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function logic [23:0] line_rd(int unsigned bank, int unsigned c);
      return lines[(bank % 2) * MAX_WIDTH + c];
    endfunction

    // Window is row-major: index row*3+col, top row first.
    function void average(logic [23:0] p [9], bit rv [3], bit cv [3], bit fe);
      int unsigned s [3];
      int unsigned n;
      blur_pix_t px;
      s = '{0, 0, 0};
      n = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          if (rv[i] && cv[j]) begin
            s[0] += p[i*3+j][23:16];
            s[1] += p[i*3+j][15:8];
            s[2] += p[i*3+j][7:0];
            n++;
          end
      px.red = 8'((2*s[0] + n) / (2*n));
      px.green = 8'((2*s[1] + n) / (2*n));
      px.blue = 8'((2*s[2] + n) / (2*n));
      px.fe = fe;
      want.push_back(px);
    endfunction

    function void note_word(blur_cmd_t cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w, h, c, d, cc;
      logic [23:0] p [9];
      logic [23:0] q [9];
      bit rv [3];
      bit cv [3];
      bit row_end;
      w = eff_w();
      h = eff_h();
      if (cmd == CMD_DRAIN) begin
        if (!draining) return;
        d = (dcol >= w) ? w - 1 : dcol;
        for (int j = 0; j < 3; j++) begin
          cc = d + j;
          cv[j] = (j != 0 || d >= 1) && cc >= 1 && cc - 1 < w;
          cc = cv[j] ? cc - 1 : d;
          p[j] = line_rd(row + 1, cc);
          p[3+j] = line_rd(row, cc);
          p[6+j] = '0;
        end
        rv = '{row >= 1, 1'b1, 1'b0};
        average(p, rv, cv, d + 1 >= w);
        if (d + 1 >= w) begin
          col = 0;
          row = 0;
          dcol = 0;
          draining = 0;
        end else begin
          dcol = d + 1;
        end
        return;
      end
      if (draining) return;
      c = (col >= w) ? w - 1 : col;
      for (int i = 0; i < 3; i++) begin
        win[i*3] = win[i*3+1];
        win[i*3+1] = win[i*3+2];
      end
      win[2] = line_rd(row, c);
      win[5] = line_rd(row + 1, c);
      win[8] = {r, g, b};
      lines[(row % 2) * MAX_WIDTH + c] = {r, g, b};
      p = win;
      rv = '{row >= 2, 1'b1, 1'b1};
      row_end = (c + 1 >= w);
      if (row >= 1 && c >= 1) begin
        cv = '{c >= 2, 1'b1, 1'b1};
        average(p, rv, cv, 1'b0);
      end
      if (row >= 1 && row_end) begin
        for (int i = 0; i < 3; i++) begin
          q[i*3] = p[i*3+1];
          q[i*3+1] = p[i*3+2];
          q[i*3+2] = '0;
        end
        cv = '{c >= 1, 1'b1, 1'b0};
        average(q, rv, cv, 1'b0);
      end
      if (row_end) begin
        col = 0;
        if (row + 1 >= h) begin
          draining = 1;
          dcol = 0;
        end else begin
          row = (row + 1) % 4096;
        end
      end else begin
        col = c + 1;
      end
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_word(blur_pix_t got);
      blur_pix_t exp;
      if (want.size() == 0) begin
        report($sformatf("unexpected word %h", got));
        return;
      end
      exp = want.pop_front();
      if (got.red !== exp.red) report($sformatf("red %h, wanted %h", got.red, exp.red));
      if (got.green !== exp.green)
        report($sformatf("green %h, wanted %h", got.green, exp.green));
      if (got.blue !== exp.blue) report($sformatf("blue %h, wanted %h", got.blue, exp.blue));
      if (got.fe !== exp.fe) report($sformatf("frame_end %b, wanted %b", got.fe, exp.fe));
    endtask
  endclass

  logic clk, rst;
  logic in_valid, in_ready, command;
  logic [7:0] red_in, green_in, blue_in;
  logic out_valid, out_ready;
  logic [7:0] red_out, green_out, blue_out;
  logic frame_end;
  logic cfg_we, cfg_index;
  logic [12:0] cfg_data;

  box_blur_3x3_edge_aware_top dut (.*);

  blur_board board = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 0;
  int unsigned cycles = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready)
      board.check_word({red_out, green_out, blue_out, frame_end});

  always @(negedge clk)
    out_ready <= !rst && !hold_off && ($urandom_range(99) >= stall_pct);

  task send(blur_cmd_t cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    command = cmd;
    red_in = r;
    green_in = g;
    blue_in = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(cmd, r, g, b);
  endtask

  task send_pixel();
    send(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Waits until nothing is expected, then lets a dropped or ignored word finish.
  task settle();
    @(negedge clk);
    in_valid = 0;
    while (board.want.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task write_reg(blur_reg_t idx, logic [12:0] value);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = value;
    board.write_reg(idx, value);
    @(negedge clk);
    cfg_we = 0;
  endtask

  // One frame of random pixels, with a little noise: stray drain ticks before
  // the frame is complete and stray pixels while it drains.
  task run_frame(logic [12:0] w, logic [12:0] h, int noise_pct);
    int unsigned ew, eh;
    settle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    ew = board.eff_w();
    eh = board.eff_h();
    for (int i = 0; i < ew * eh; i++) begin
      if ($urandom_range(99) < noise_pct)
        send(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
      send_pixel();
    end
    for (int i = 0; i < ew; i++) begin
      if ($urandom_range(99) < noise_pct) send_pixel();
      send(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int n;
    board.reset_state();
    rst = 1;
    in_valid = 0;
    command = CMD_PIXEL;
    red_in = 0;
    green_in = 0;
    blue_in = 0;
    cfg_we = 0;
    cfg_index = REG_WIDTH;
    cfg_data = 0;
    repeat (4) @(negedge clk);
    rst = 0;

    // Directed: a 3x3 frame of extreme values, an ignored drain tick first and
    // a dropped pixel during the drain.
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    send(CMD_DRAIN, 8'hff, 8'hff, 8'hff);
    for (int i = 0; i < 9; i++)
      if (i % 2 == 0) send(CMD_PIXEL, 8'hff, 8'h00, 8'hff);
      else send(CMD_PIXEL, 8'h00, 8'hff, 8'h00);
    send(CMD_DRAIN, 0, 0, 0);
    send(CMD_PIXEL, 8'hff, 8'hff, 8'hff);
    send(CMD_DRAIN, 0, 0, 0);
    send(CMD_DRAIN, 0, 0, 0);
    run_frame(0, 0, 0);
    run_frame(1, 1, 0);
    run_frame(2, 1, 0);
    run_frame(1, 3, 0);

    // Random frames under each idling pattern.
    n = 0;
    while (n < 600) begin
      case ((n / 150) % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 52; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 52; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      run_frame($urandom_range(1, 9), $urandom_range(1, 6), 10);
      n += board.eff_w() * (board.eff_h() + 1);
    end

    // Long receiver hold-off while the sender keeps offering pixels.
    send_idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      run_frame(8, 6, 0);
    join

    settle();
    repeat (50) @(negedge clk);
    if (board.errors == 0 && board.want.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
